FILE: hw/rtl/rfm_pkg.sv
// Shared constants, codes and result type for the real-time/MLFQ task scheduler.
package rfm_pkg;

    localparam int TASK_SLOTS_DEF  = 16;
    localparam int USER_LEVELS_DEF = 3;

    localparam int ID_W    = 4;
    localparam int PRIO_W  = 3;
    localparam int TICKS_W = 8;
    localparam int LVL_O_W = 2;
    localparam int ST_W    = 2;
    localparam int OC_W    = 2;

    localparam logic [TICKS_W-1:0] CPU_LIMIT_RST = 8'd20;
    localparam logic [TICKS_W-1:0] TICKS_MAX     = 8'd255;

    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_ARRIVAL = 1'b1;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD_PRIO = 2'd1;
    localparam logic [ST_W-1:0] ST_BUSY     = 2'd2;

    localparam logic [OC_W-1:0] OC_RUN  = 2'd0;
    localparam logic [OC_W-1:0] OC_FIN  = 2'd1;
    localparam logic [OC_W-1:0] OC_STOP = 2'd2;
    localparam logic [OC_W-1:0] OC_REQ  = 2'd3;

    typedef struct packed {
        logic               tick;
        logic [ST_W-1:0]    status;
        logic               idle;
        logic [ID_W-1:0]    ran_task;
        logic               rt;
        logic               first;
        logic [OC_W-1:0]    outcome;
        logic [TICKS_W-1:0] remaining;
        logic [TICKS_W-1:0] cpu_used;
        logic [LVL_O_W-1:0] next_level;
    } t_result;

endpackage

FILE: hw/rtl/rfm_fifo.sv
// Circular register queue of task slots with head peek, push and pop.
module rfm_fifo
    import rfm_pkg::*;
#(
    parameter int DEPTH = TASK_SLOTS_DEF,
    parameter int W     = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_din,
    input  logic         i_pop,
    output logic [W-1:0] o_head,
    output logic         o_nempty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_head;
    logic [PW-1:0] r_tail;
    logic [CW-1:0] r_count;

    logic do_pop;
    logic do_push;

    // a pop in the same cycle frees room for the push
    assign do_pop   = i_pop && (r_count != '0);
    assign do_push  = i_push && ((r_count != CNT_FULL) || do_pop);
    assign o_head   = r_mem[r_head];
    assign o_nempty = (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (do_pop) begin
                r_head <= (r_head == PTR_LAST) ? '0 : r_head + 1'b1;
            end
            if (do_push) begin
                r_tail <= (r_tail == PTR_LAST) ? '0 : r_tail + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_tail] <= i_din;
        end
    end

endmodule

FILE: hw/rtl/rfm_core.sv
// Task table, run queues and combinational arrival/tick decision logic.
module rfm_core
    import rfm_pkg::*;
#(
    parameter int TASK_SLOTS  = TASK_SLOTS_DEF,
    parameter int USER_LEVELS = USER_LEVELS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_go,
    input  logic               i_kind,
    input  logic [ID_W-1:0]    i_task_id,
    input  logic [PRIO_W-1:0]  i_prio,
    input  logic [TICKS_W-1:0] i_burst,
    input  logic [TICKS_W-1:0] i_cpu_limit,
    output t_result            o_res
);

    localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int LW = (USER_LEVELS > 1) ? $clog2(USER_LEVELS) : 1;
    localparam logic [LW-1:0] LVL_LAST = LW'(USER_LEVELS - 1);

    logic [TICKS_W-1:0] r_rem  [TASK_SLOTS];
    logic [TICKS_W-1:0] r_used [TASK_SLOTS];
    logic [LW-1:0]      r_lvl  [TASK_SLOTS];
    logic [TASK_SLOTS-1:0] r_active;
    logic               r_rt_valid;
    logic [SW-1:0]      r_rt_slot;

    logic               is_arr;
    logic               is_tick;
    logic               bad_prio;
    logic               busy;
    logic               arr_ok;
    logic [SW-1:0]      arr_slot;
    logic [LW-1:0]      arr_lvl;

    logic [SW-1:0]      rt_head;
    logic               rt_ne;
    logic               rt_run;
    logic [SW-1:0]      rt_slot;
    logic [SW-1:0]      u_head [USER_LEVELS];
    logic [USER_LEVELS-1:0] u_ne;
    logic               u_found;
    logic [LW-1:0]      u_lvl;

    logic               run;
    logic [SW-1:0]      slot;
    logic [TICKS_W-1:0] cur_rem;
    logic [TICKS_W-1:0] cur_used;
    logic [LW-1:0]      cur_lvl;
    logic [TICKS_W-1:0] rem_n;
    logic [TICKS_W-1:0] used_n;
    logic [LW-1:0]      nlvl;
    logic [OC_W-1:0]    outcome;
    logic               done;
    logic               req;

    assign is_arr   = (i_kind == KIND_ARRIVAL);
    assign is_tick  = (i_kind == KIND_TICK);
    assign bad_prio = 32'(i_prio) > USER_LEVELS;
    assign arr_slot = SW'(i_task_id);
    assign busy     = (32'(i_task_id) >= TASK_SLOTS) || r_active[arr_slot];
    assign arr_ok   = is_arr && !bad_prio && !busy;
    assign arr_lvl  = LW'(i_prio - 3'd1);

    assign rt_run  = r_rt_valid || rt_ne;
    assign rt_slot = r_rt_valid ? r_rt_slot : rt_head;

    always_comb begin
        u_found = 1'b0;
        u_lvl   = '0;
        for (int l = USER_LEVELS - 1; l >= 0; l--) begin
            if (u_ne[l]) begin
                u_found = 1'b1;
                u_lvl   = LW'(l);
            end
        end
    end

    assign run      = is_tick && (rt_run || u_found);
    assign slot     = rt_run ? rt_slot : u_head[u_lvl];
    assign cur_rem  = r_rem[slot];
    assign cur_used = r_used[slot];
    assign cur_lvl  = r_lvl[slot];
    assign rem_n    = (cur_rem == '0) ? '0 : cur_rem - 1'b1;
    assign used_n   = (cur_used == TICKS_MAX) ? TICKS_MAX : cur_used + 1'b1;
    assign nlvl     = (cur_lvl == LVL_LAST) ? cur_lvl : cur_lvl + 1'b1;

    always_comb begin
        priority if (rem_n == '0) begin
            outcome = OC_FIN;
        end else if (used_n >= i_cpu_limit) begin
            outcome = OC_STOP;
        end else if (rt_run) begin
            outcome = OC_RUN;
        end else begin
            outcome = OC_REQ;
        end
    end

    assign done = run && ((outcome == OC_FIN) || (outcome == OC_STOP));
    assign req  = run && (outcome == OC_REQ);

    rfm_fifo #(
        .DEPTH (TASK_SLOTS),
        .W     (SW)
    ) u_rt_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_go && arr_ok && (i_prio == '0)),
        .i_din    (arr_slot),
        .i_pop    (i_go && is_tick && !r_rt_valid),
        .o_head   (rt_head),
        .o_nempty (rt_ne)
    );

    for (genvar l = 0; l < USER_LEVELS; l++) begin : g_user
        rfm_fifo #(
            .DEPTH (TASK_SLOTS),
            .W     (SW)
        ) u_fifo (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_push   (i_go && ((arr_ok && (32'(i_prio) == l + 1))
                                || (req && (nlvl == LW'(l))))),
            .i_din    (is_arr ? arr_slot : slot),
            .i_pop    (i_go && is_tick && !rt_run && u_found && (u_lvl == LW'(l))),
            .o_head   (u_head[l]),
            .o_nempty (u_ne[l])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= '0;
            r_rt_valid <= 1'b0;
            r_rt_slot  <= '0;
        end else if (i_go) begin
            if (arr_ok) begin
                r_active[arr_slot] <= 1'b1;
            end
            if (done) begin
                r_active[slot] <= 1'b0;
            end
            if (is_tick) begin
                r_rt_valid <= rt_run && !done;
                if (rt_run) begin
                    r_rt_slot <= rt_slot;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go && arr_ok) begin
            r_rem[arr_slot]  <= i_burst;
            r_used[arr_slot] <= '0;
            r_lvl[arr_slot]  <= arr_lvl;
        end else if (i_go && run) begin
            r_rem[slot]  <= rem_n;
            r_used[slot] <= used_n;
            if (req) begin
                r_lvl[slot] <= nlvl;
            end
        end
    end

    always_comb begin
        o_res = '0;
        if (is_arr) begin
            priority if (bad_prio) begin
                o_res.status = ST_BAD_PRIO;
            end else if (busy) begin
                o_res.status = ST_BUSY;
            end else begin
                o_res.status = ST_OK;
            end
        end else begin
            o_res.tick = 1'b1;
            if (run) begin
                o_res.ran_task   = ID_W'(slot);
                o_res.rt         = rt_run;
                o_res.first      = (cur_used == '0);
                o_res.outcome    = outcome;
                o_res.remaining  = rem_n;
                o_res.cpu_used   = used_n;
                o_res.next_level = req ? LVL_O_W'(nlvl) : '0;
            end else begin
                o_res.idle = 1'b1;
            end
        end
    end

endmodule

FILE: hw/rtl/rt_fcfs_mlfq_scheduler.sv
// Real-time FCFS plus multilevel feedback queue task scheduler, top level.
//
// Requests enter on the s_axis channel: tuser 1 is a task arrival (slot, priority,
// burst), tuser 0 is one scheduling tick. Each request yields exactly one result on
// m_axis, in order; m_axis_tuser marks tick results.
// A request is held in the input stage register, passes the slot table and register
// queues combinationally and is registered in the result stage, which drives
// m_axis_tvalid; one request per cycle is sustained while m_axis_tready stays high.
// The cfg channel writes the CPU tick limit; it is always ready. The user must write it
// only while no request is in flight; the block itself leaves this unenforced.
// Reset (synchronous, active low) empties all queues, frees every slot, clears the
// running real-time task and sets the limit to 20. Table contents are not cleared.
// When m_axis_tready is low the result holds and one more request is taken into the
// input stage; s_axis_tready then drops until the result is taken.
module rt_fcfs_mlfq_scheduler
    import rfm_pkg::*;
#(
    parameter int TASK_SLOTS  = TASK_SLOTS_DEF,
    parameter int USER_LEVELS = USER_LEVELS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [15:0]        s_axis_tdata,   // task_id[3:0], priority_req[6:4], burst[14:7]
    input  logic               s_axis_tuser,   // kind
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [31:0]        m_axis_tdata,   // arrival_status[1:0], idle[2], ran_task[6:3],
                                               // realtime_res[7], first_run[8], outcome[10:9],
                                               // remaining_after[18:11], cpu_used_after[26:19],
                                               // next_level[28:27]
    output logic               m_axis_tuser,   // tick_result
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [TICKS_W-1:0] i_cfg_data
);

    logic               r_in_valid;
    logic               r_in_kind;
    logic [ID_W-1:0]    r_in_id;
    logic [PRIO_W-1:0]  r_in_prio;
    logic [TICKS_W-1:0] r_in_burst;
    logic               r_out_valid;
    t_result            r_out;
    logic [TICKS_W-1:0] r_cpu_limit;
    t_result            n_out;
    logic               adv;

    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cpu_limit <= CPU_LIMIT_RST;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_cpu_limit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_kind  <= s_axis_tuser;
            r_in_id    <= s_axis_tdata[3:0];
            r_in_prio  <= s_axis_tdata[6:4];
            r_in_burst <= s_axis_tdata[14:7];
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    rfm_core #(
        .TASK_SLOTS  (TASK_SLOTS),
        .USER_LEVELS (USER_LEVELS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (adv),
        .i_kind      (r_in_kind),
        .i_task_id   (r_in_id),
        .i_prio      (r_in_prio),
        .i_burst     (r_in_burst),
        .i_cpu_limit (r_cpu_limit),
        .o_res       (n_out)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.tick;
    assign m_axis_tdata  = {3'd0, r_out.next_level, r_out.cpu_used, r_out.remaining,
                            r_out.outcome, r_out.first, r_out.rt, r_out.ran_task,
                            r_out.idle, r_out.status};

`ifndef ASSERT_OFF
    a_hold_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !m_axis_tready |=> r_in_valid)
        else $error("pending request dropped during output stall");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> s_axis_tready)
        else $error("input stage empty but not ready");

    a_arrival_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[28:2] == '0)
        else $error("arrival result carries tick fields");

    a_tick_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[1:0] == ST_OK)
        else $error("tick result carries arrival status");
`endif

endmodule
